// ===== rtl/sliding_window_average3_defines.svh =====
// Assertion macros used by the controller (swa3_ctrl) of the moving average block.
`ifndef SLIDING_WINDOW_AVERAGE3_DEFINES_SVH
`define SLIDING_WINDOW_AVERAGE3_DEFINES_SVH

`ifndef SYNTHESIS
`define SWA3_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SWA3_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SWA3_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define SWA3_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/swa3_pkg.sv =====
package swa3_pkg;

  localparam int DATA_W  = 32;
  localparam int TOTAL_W = 40;
  localparam int COUNT_W = 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_DIV_START,
    S_DIV_WAIT,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    CH_X,
    CH_Y,
    CH_T
  } chan_t;

  typedef struct packed {
    logic  load;
    logic  update;
    logic  div_start;
    chan_t div_sel;
    logic  div_store;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

endpackage

// ===== rtl/swa3_div.sv =====
module swa3_div import swa3_pkg::*; #(
  parameter int DIV_W = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [TOTAL_W-1:0] dividend,
  input  logic [DIV_W-1:0]          divisor,
  output logic                      done,
  output logic signed [DATA_W-1:0]  quotient
);

  localparam int STEP_W = $clog2(TOTAL_W + 1);

  logic               busy;
  logic [STEP_W-1:0]  cnt;
  logic [TOTAL_W-1:0] quo;
  logic [DIV_W:0]     rem;
  logic               neg;
  logic [TOTAL_W-1:0] mag;
  logic [DIV_W:0]     trial;
  logic [DIV_W:0]     diff;
  logic               ge;
  logic [TOTAL_W-1:0] q_signed;

  always_comb begin
    mag      = dividend[TOTAL_W-1] ? TOTAL_W'(-dividend) : TOTAL_W'(dividend);
    trial    = {rem[DIV_W-1:0], quo[TOTAL_W-1]};
    ge       = (trial >= {1'b0, divisor});
    diff     = trial - {1'b0, divisor};
    done     = busy && (cnt == '0);
    q_signed = neg ? TOTAL_W'(-quo) : quo;
    quotient = q_signed[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= STEP_W'(TOTAL_W);
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= mag;
      rem <= '0;
      neg <= dividend[TOTAL_W-1];
    end else if (busy && (cnt != '0)) begin
      rem <= ge ? diff : trial;
      quo <= {quo[TOTAL_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/swa3_dp.sv =====
module swa3_dp import swa3_pkg::*; #(
  parameter int WINDOW = 132
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output status_t                  status,
  input  logic signed [DATA_W-1:0] sample_x,
  input  logic signed [DATA_W-1:0] sample_y,
  input  logic signed [DATA_W-1:0] sample_t,
  output logic signed [DATA_W-1:0] mean_x,
  output logic signed [DATA_W-1:0] mean_y,
  output logic signed [DATA_W-1:0] mean_t,
  output logic [COUNT_W-1:0]       held_count
);

  localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FW = $clog2(WINDOW + 1);

  logic [3*DATA_W-1:0]        ring [WINDOW];
  logic [3*DATA_W-1:0]        rd_data;
  logic [SW-1:0]              slot;
  logic [FW-1:0]              fill;
  logic signed [TOTAL_W-1:0]  total_x;
  logic signed [TOTAL_W-1:0]  total_y;
  logic signed [TOTAL_W-1:0]  total_t;
  logic signed [DATA_W-1:0]   sx, sy, st;
  logic signed [DATA_W-1:0]   q_x, q_y, q_t;
  logic                       full;
  logic signed [TOTAL_W-1:0]  old_x, old_y, old_t;
  logic signed [TOTAL_W-1:0]  div_dividend;
  logic signed [DATA_W-1:0]   div_quotient;
  logic                       div_done;
  logic [FW+COUNT_W-1:0]      fill_ext;

  assign full     = (fill == FW'(WINDOW));
  assign fill_ext = {{COUNT_W{1'b0}}, fill};

  always_comb begin
    old_x = full ? TOTAL_W'(signed'(rd_data[3*DATA_W-1:2*DATA_W])) : '0;
    old_y = full ? TOTAL_W'(signed'(rd_data[2*DATA_W-1:DATA_W])) : '0;
    old_t = full ? TOTAL_W'(signed'(rd_data[DATA_W-1:0])) : '0;
    case (cmd.div_sel)
      CH_X:    div_dividend = total_x;
      CH_Y:    div_dividend = total_y;
      CH_T:    div_dividend = total_t;
      default: div_dividend = total_x;
    endcase
  end

  // ring: read the oldest entry on load, overwrite it on update
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_data <= ring[slot];
    end
    if (cmd.update) begin
      ring[slot] <= {sx, sy, st};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx <= sample_x;
      sy <= sample_y;
      st <= sample_t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot    <= '0;
      fill    <= '0;
      total_x <= '0;
      total_y <= '0;
      total_t <= '0;
    end else if (cmd.update) begin
      total_x <= total_x + TOTAL_W'(sx) - old_x;
      total_y <= total_y + TOTAL_W'(sy) - old_y;
      total_t <= total_t + TOTAL_W'(st) - old_t;
      slot    <= (slot == SW'(WINDOW - 1)) ? '0 : slot + 1'b1;
      if (!full) begin
        fill <= fill + 1'b1;
      end
    end
  end

  swa3_div #(
    .DIV_W (FW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (fill),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign status.div_done = div_done;

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      case (cmd.div_sel)
        CH_X:    q_x <= div_quotient;
        CH_Y:    q_y <= div_quotient;
        CH_T:    q_t <= div_quotient;
        default: q_x <= div_quotient;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mean_x     <= q_x;
      mean_y     <= q_y;
      mean_t     <= q_t;
      held_count <= fill_ext[COUNT_W-1:0];
    end
  end

endmodule

// ===== rtl/swa3_ctrl.sv =====
`include "sliding_window_average3_defines.svh"

module swa3_ctrl import swa3_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output cmd_t    cmd,
  input  status_t status
);

  state_t state, state_next;
  chan_t  chan, chan_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      chan  <= CH_X;
    end else begin
      state <= state_next;
      chan  <= chan_next;
    end
  end

  always_comb begin
    state_next    = state;
    chan_next     = chan;
    cmd           = '0;
    cmd.div_sel   = chan;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        chan_next  = CH_X;
        state_next = S_DIV_START;
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.div_store = 1'b1;
          case (chan)
            CH_X:    begin chan_next = CH_Y; state_next = S_DIV_START; end
            CH_Y:    begin chan_next = CH_T; state_next = S_DIV_START; end
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `SWA3_ASSERT_IMPL(a_load_free, clk, rst, cmd.out_load, !out_valid || !out_stall)
  `SWA3_ASSERT_IMPL(a_done_wait, clk, rst, status.div_done, state == S_DIV_WAIT)
  `SWA3_ASSERT_NEXT(a_accept_upd, clk, rst, in_valid && !in_stall, state == S_UPDATE)

endmodule

// ===== rtl/sliding_window_average3.sv =====
// Moving average of three channels (x, y, t) over the newest WINDOW samples.
// Input channel: in_valid/in_stall with sample_x, sample_y (signed Q16.16)
// and sample_t (signed integer). A transaction completes when in_valid is
// high and in_stall is low. Output channel: out_valid/out_stall with
// mean_x, mean_y, mean_t and held_count; every input transaction yields
// exactly one output transaction.
// out_valid rises after these steps: the accepting edge reads the
// oldest ring entry, the next one updates the 40-bit running totals, then
// three 40-step divisions by the fill count run on one shared restoring
// divider, then the output register is loaded. The next sample is accepted
// the cycle after that load; the block takes no new sample while one is
// being computed.
// Means truncate toward zero. held_count is the fill count, low 8 bits.
// Reset (rst, synchronous) empties the window and drops any pending
// output; the sample ring itself is not cleared. If the receiver stalls,
// the output register holds its transaction; a new sample is still taken
// and computed, and it waits before the output load until the register
// frees.
module sliding_window_average3 import swa3_pkg::*; #(
  parameter int WINDOW = 132
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] sample_x,
  input  logic signed [DATA_W-1:0] sample_y,
  input  logic signed [DATA_W-1:0] sample_t,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] mean_x,
  output logic signed [DATA_W-1:0] mean_y,
  output logic signed [DATA_W-1:0] mean_t,
  output logic [COUNT_W-1:0]       held_count
);

  cmd_t    cmd;
  status_t status;

  // sequencing: accept, update totals, three divisions, load output
  swa3_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // ring, running totals, fill count, divider and output register
  swa3_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .sample_x   (sample_x),
    .sample_y   (sample_y),
    .sample_t   (sample_t),
    .mean_x     (mean_x),
    .mean_y     (mean_y),
    .mean_t     (mean_t),
    .held_count (held_count)
  );

endmodule

// ===== test/tb_sliding_window_average3.sv =====
module tb_sliding_window_average3 import swa3_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Window length under test and the bounds of the run.
  localparam int WIN_LEN     = 132;
  localparam int HOLD_CYCLES = 3000;   // long receiver hold-off
  localparam int IDLE_LIMIT  = 20000;  // cycles with no transaction before giving up
  localparam int DRAIN_WAIT  = 300;    // extra wait after the last result for any unexpected output
  localparam int EXP_DEPTH   = 16;     // expectation buffer, far above what can be in flight

  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sh0001_0000;

  // Receiver behavior for one stretch of cycles.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HALF,
    STALL_HEAVY
  } stall_mode_t;

  // One expected output transaction: three means and the fill count.
  typedef struct packed {
    logic signed [DATA_W-1:0] avg_x;
    logic signed [DATA_W-1:0] avg_y;
    logic signed [DATA_W-1:0] avg_t;
    logic [COUNT_W-1:0]       count;
  } window_means_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [DATA_W-1:0]  sample_x;
  logic signed [DATA_W-1:0]  sample_y;
  logic signed [DATA_W-1:0]  sample_t;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [DATA_W-1:0]  mean_x;
  logic signed [DATA_W-1:0]  mean_y;
  logic signed [DATA_W-1:0]  mean_t;
  logic [COUNT_W-1:0]        held_count;

  // Shadow of the block: ring, write slot, fill count and 40-bit running sums.
  logic signed [DATA_W-1:0]  win_x [WIN_LEN];
  logic signed [DATA_W-1:0]  win_y [WIN_LEN];
  logic signed [DATA_W-1:0]  win_t [WIN_LEN];
  int unsigned               next_slot;
  int unsigned               held_samples;
  logic signed [39:0]        sum_x;
  logic signed [39:0]        sum_y;
  logic signed [39:0]        sum_t;

  // Expected results in order: the sender advances the tail, the checker the head.
  window_means_t             exp_mem [EXP_DEPTH];
  logic [3:0]                exp_head;
  logic [3:0]                exp_tail;
  int                        error_count;
  int                        burst_left;
  bit                        hold_off_req;

  sliding_window_average3 #(
    .WINDOW(WIN_LEN)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_x  (sample_x),
    .sample_y  (sample_y),
    .sample_t  (sample_t),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .mean_x    (mean_x),
    .mean_y    (mean_y),
    .mean_t    (mean_t),
    .held_count(held_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Signed 40-bit total over the count, truncated toward zero, low 32 bits kept.
  function automatic logic signed [DATA_W-1:0] trunc_mean(input logic signed [39:0] total,
                                                         input int unsigned n);
    longint q;
    q = longint'(total) / longint'(n);
    return q[DATA_W-1:0];
  endfunction

  // Push one sample into the shadow window and return the means it yields.
  function automatic window_means_t push_and_average(input logic signed [DATA_W-1:0] x,
                                                     input logic signed [DATA_W-1:0] y,
                                                     input logic signed [DATA_W-1:0] t);
    window_means_t r;
    // Drop the oldest sample from the sums once the ring is full.
    if (held_samples >= WIN_LEN) begin
      sum_x = sum_x - win_x[next_slot];
      sum_y = sum_y - win_y[next_slot];
      sum_t = sum_t - win_t[next_slot];
    end else begin
      held_samples++;
    end
    sum_x = sum_x + x;
    sum_y = sum_y + y;
    sum_t = sum_t + t;
    win_x[next_slot] = x;
    win_y[next_slot] = y;
    win_t[next_slot] = t;
    next_slot = (next_slot + 1) % WIN_LEN;
    r.avg_x = trunc_mean(sum_x, held_samples);
    r.avg_y = trunc_mean(sum_y, held_samples);
    r.avg_t = trunc_mean(sum_t, held_samples);
    r.count = held_samples[COUNT_W-1:0];
    return r;
  endfunction

  // Mix of value classes: extremes, tiny integers, small Q16.16 values, full range.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return $signed($urandom_range(0, 64)) - 32;
      3: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      default: return $signed($urandom);
    endcase
  endfunction

  // Offer one sample and hold it until the block takes it. The sender works in
  // bursts; at the end of a burst drop valid for a random gap.
  task automatic send_sample(input logic signed [DATA_W-1:0] x,
                             input logic signed [DATA_W-1:0] y,
                             input logic signed [DATA_W-1:0] t);
    int gap;
    if (burst_left == 0) begin
      if (in_valid) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
    end
    burst_left--;
    sample_x <= x;
    sample_y <= y;
    sample_t <= t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_mem[exp_tail] = push_and_average(x, y, t);
    exp_tail = exp_tail + 4'd1;
  endtask

  task automatic send_random(input int n);
    repeat (n) send_sample(pick_value(), pick_value(), pick_value());
  endtask

  // Extremes, sign mixes, truncation of negative means toward zero, bit patterns.
  task automatic test_directed();
    send_sample(VAL_MAX, VAL_MIN, 32'sd0);
    send_sample(VAL_MAX, VAL_MIN, -32'sd1);     // t mean -1/2 truncates to zero
    send_sample(VAL_MIN, VAL_MAX, 32'sd1);
    send_sample(32'sd0, 32'sd0, 32'sd0);
    send_sample(-32'sd1, -32'sd1, -32'sd1);
    send_sample(32'sd1, 32'sd1, 32'sd1);
    send_sample(VAL_MIN, VAL_MIN, VAL_MIN);
    send_sample(VAL_MIN, VAL_MIN, VAL_MIN);
    send_sample(VAL_MAX, VAL_MAX, VAL_MAX);
    send_sample(Q_ONE, -Q_ONE, 32'sd7);
    send_sample(-32'sd7, 32'sd7, -32'sh8000);
    send_sample(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_FFFF);
    send_sample(32'shAAAA_AAAA, 32'sh5555_5555, 32'shFFFF_0000);
    send_sample(32'shFFFF_0000, 32'sh0000_FFFF, 32'sh5555_5555);
    send_sample(32'sh0000_FFFF, 32'shFFFF_0000, 32'shAAAA_AAAA);
    send_sample(-Q_ONE, Q_ONE, -32'sd3);
  endtask

  // Fill the window beyond capacity with extremes so the sums approach their
  // widest values, then flip signs so every held sample gets replaced.
  task automatic test_full_scale_window();
    repeat (WIN_LEN + 4)
      send_sample(VAL_MIN, VAL_MAX, $urandom_range(0, 1) ? VAL_MAX : VAL_MIN);
    repeat (WIN_LEN + 4)
      send_sample(VAL_MAX, VAL_MIN, $urandom_range(0, 1) ? VAL_MAX : VAL_MIN);
  endtask

  task automatic test_random_stream();
    send_random(220);
  endtask

  // Hold the receiver off for a long stretch while samples keep coming, so the
  // output register fills, the next result parks and the input stalls.
  task automatic test_backpressure();
    burst_left = 20;
    hold_off_req = 1'b1;
    send_random(12);
  endtask

  // Pause the sender until every pending result is out, then resume.
  task automatic test_drain_pause();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (exp_head != exp_tail) @(posedge clk);
    send_random(130);
  endtask

  // Receiver: stall on a pattern of its own, in stretches of random length,
  // and honor a long hold-off request by counting its cycles here.
  initial begin
    stall_mode_t mode;
    int          stretch_left;
    int          hold_left;
    mode         = STALL_NONE;
    stretch_left = 0;
    hold_left    = 0;
    out_stall   <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (stretch_left == 0) begin
          mode         = stall_mode_t'($urandom_range(0, 3));
          stretch_left = $urandom_range(20, 600);
        end
        stretch_left--;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
          default:     out_stall <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Compare every output transaction with the oldest pending expectation.
  always @(posedge clk) begin
    window_means_t want;
    if (!rst && out_valid && !out_stall) begin
      if (exp_head == exp_tail) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: x=%0d y=%0d t=%0d n=%0d",
                   mean_x, mean_y, mean_t, held_count);
      end else begin
        want     = exp_mem[exp_head];
        exp_head = exp_head + 4'd1;
        if (mean_x !== want.avg_x || mean_y !== want.avg_y ||
            mean_t !== want.avg_t || held_count !== want.count) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: exp x=%0d y=%0d t=%0d n=%0d got x=%0d y=%0d t=%0d n=%0d",
                     want.avg_x, want.avg_y, want.avg_t, want.count,
                     mean_x, mean_y, mean_t, held_count);
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves on either side for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    next_slot    = 0;
    held_samples = 0;
    sum_x        = '0;
    sum_y        = '0;
    sum_t        = '0;
    exp_head     = '0;
    exp_tail     = '0;
    error_count  = 0;
    burst_left   = 0;
    hold_off_req = 1'b0;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    sample_x    <= '0;
    sample_y    <= '0;
    sample_t    <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_full_scale_window();
    test_random_stream();
    test_backpressure();
    test_drain_pause();

    // Drop valid, wait for the last results, then give the block time to
    // misbehave with anything extra.
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_head != exp_tail) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (error_count == 0 && exp_head == exp_tail)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/swa3_pkg.sv
rtl/swa3_div.sv
rtl/swa3_dp.sv
rtl/swa3_ctrl.sv
rtl/sliding_window_average3.sv
test/tb_sliding_window_average3.sv
